// ===== rtl/bped_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bped_pkg;

   // Number of buttons tracked by the state file and the width of a button index.
   localparam int NUM_BUTTONS = 8;
   localparam int BTN_IDX_W   = 3;
   localparam int COUNT_W     = 16;
   localparam int BCOUNT_W    = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Event codes reported per button.
   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_CLICK_DOWN = 3'd1,
      EV_HOLD       = 3'd2,
      EV_HOLD_CYCLE = 3'd3,
      EV_CLICK_UP   = 3'd4,
      EV_HOLD_UP    = 3'd5
   } btn_event_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUTTON_COUNT     = 3'd0,
      CSR_PRESS_LEVEL_MASK = 3'd1,
      CSR_DOWN_TICKS       = 3'd2,
      CSR_HOLD_TICKS       = 3'd3,
      CSR_HOLD_CYCLE_TICKS = 3'd4
   } csr_index_type;

   // Current configuration, passed from the register block to the core.
   typedef struct packed {
      logic [BCOUNT_W-1:0]    button_count;
      logic [NUM_BUTTONS-1:0] press_level_mask;
      logic [COUNT_W-1:0]     down_ticks;
      logic [COUNT_W-1:0]     hold_ticks;
      logic [COUNT_W-1:0]     hold_cycle_ticks;
   } cfg_type;

   // One request: a scan sample of one button.
   typedef struct packed {
      logic [BTN_IDX_W-1:0] button_index;
      logic                 pin_level;
   } req_type;

   // One result.
   typedef struct packed {
      btn_event_type        button_event;
      logic                 notify;
      logic [BTN_IDX_W-1:0] echo_index;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/bped_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bped_csr
   import bped_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always accepted.
   assign csr_ready = 1'b1;

   // Register write decode; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BUTTON_COUNT:     cfg_in.button_count     = csr_data[BCOUNT_W-1:0];
            CSR_PRESS_LEVEL_MASK: cfg_in.press_level_mask = csr_data[NUM_BUTTONS-1:0];
            CSR_DOWN_TICKS:       cfg_in.down_ticks       = csr_data[COUNT_W-1:0];
            CSR_HOLD_TICKS:       cfg_in.hold_ticks       = csr_data[COUNT_W-1:0];
            CSR_HOLD_CYCLE_TICKS: cfg_in.hold_cycle_ticks = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_count     <= '0;
         cfg_ff.press_level_mask <= '0;
         cfg_ff.down_ticks       <= COUNT_W'(3);
         cfg_ff.hold_ticks       <= COUNT_W'(100);
         cfg_ff.hold_cycle_ticks <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bped_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bped_core
   import bped_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    step_en,
   input  wire req_type item,
   output rsp_type      result
);

   // Per-button state file.
   logic [COUNT_W-1:0] press_count_ff  [NUM_BUTTONS];
   logic [COUNT_W-1:0] cycle_phase_ff  [NUM_BUTTONS];
   logic               press_active_ff [NUM_BUTTONS];
   btn_event_type      last_event_ff   [NUM_BUTTONS];

   logic [COUNT_W-1:0] press_count_in;
   logic [COUNT_W-1:0] cycle_phase_in;
   logic               press_active_in;
   btn_event_type      last_event_in;

   logic [BTN_IDX_W-1:0] idx;
   logic                 registered;
   logic                 pressed;
   logic [COUNT_W-1:0]   old_count;
   logic [COUNT_W-1:0]   count_step;
   logic                 stepped;
   logic [COUNT_W:0]     phase_inc;
   logic                 notify;

   assign idx        = item.button_index;
   assign registered = {1'b0, idx} < cfg.button_count;
   assign pressed    = item.pin_level == cfg.press_level_mask[idx];
   assign old_count  = press_count_ff[idx];
   assign stepped    = old_count != COUNT_MAX;
   assign count_step = old_count + COUNT_W'(stepped);
   assign phase_inc  = {1'b0, cycle_phase_ff[idx]} + (COUNT_W+1)'(1);

   // Next state of the addressed button and the notify flag.
   always_comb begin
      press_count_in  = old_count;
      cycle_phase_in  = cycle_phase_ff[idx];
      press_active_in = press_active_ff[idx];
      last_event_in   = last_event_ff[idx];
      notify          = 1'b0;
      if (pressed) begin
         press_count_in = count_step;
         if (cfg.hold_cycle_ticks == '0) begin
            cycle_phase_in = '0;
         end else if (phase_inc >= {1'b0, cfg.hold_cycle_ticks}) begin
            cycle_phase_in = '0;
         end else begin
            cycle_phase_in = phase_inc[COUNT_W-1:0];
         end
         if (stepped && count_step == cfg.down_ticks) begin
            press_active_in = 1'b1;
            last_event_in   = EV_CLICK_DOWN;
            notify          = 1'b1;
         end else if (stepped && count_step == cfg.hold_ticks) begin
            press_active_in = 1'b1;
            last_event_in   = EV_HOLD;
            notify          = 1'b1;
         end else if (count_step > cfg.hold_ticks) begin
            last_event_in = EV_HOLD_CYCLE;
            notify        = (cfg.hold_cycle_ticks != '0) && (cycle_phase_in == '0);
         end
      end else begin
         press_count_in = '0;
         cycle_phase_in = '0;
         if (press_active_ff[idx]) begin
            if (old_count >= cfg.down_ticks && old_count < cfg.hold_ticks) begin
               last_event_in = EV_CLICK_UP;
               notify        = 1'b1;
            end else if (old_count >= cfg.hold_ticks) begin
               last_event_in = EV_HOLD_UP;
               notify        = 1'b1;
            end
            press_active_in = 1'b0;
         end
      end
   end

   // Result of this sample; an unregistered button reports nothing.
   always_comb begin
      result.echo_index = idx;
      if (registered) begin
         result.button_event = last_event_in;
         result.notify       = notify;
      end else begin
         result.button_event = EV_NONE;
         result.notify       = 1'b0;
      end
   end

   // State write-back for registered buttons.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_count_ff[i]  <= '0;
            cycle_phase_ff[i]  <= '0;
            press_active_ff[i] <= 1'b0;
            last_event_ff[i]   <= EV_NONE;
         end
      end else if (step_en && registered) begin
         press_count_ff[idx]  <= press_count_in;
         cycle_phase_ff[idx]  <= cycle_phase_in;
         press_active_ff[idx] <= press_active_in;
         last_event_ff[idx]   <= last_event_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/button_press_event_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Button click and hold event detector. Each request carries one scan sample of
// one button's pin; each request gives exactly one response with the button's
// current event, a notify flag and the echoed index. A request passes an input
// register and then the per-button read, modify and write logic into the
// response register, so one request is accepted every clock cycle while the
// response side is not stalled. Samples for the same button may follow each
// other back to back, since the state file is written in the same cycle that
// the response register loads. Configuration writes should be made while no
// request is in flight.
module button_press_event_detector
   import bped_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;
   logic    advance;
   logic    req_fire;

   bped_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bped_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (s1_data_ff),
      .result  (core_result)
   );

   // Pipeline flow: the input stage moves on when the response register is free.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/button_press_event_detector_tb.sv =====
`timescale 1ns / 1ps

module button_press_event_detector_tb;
   import bped_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_SAMPLES  = 225;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR
   } row_kind_type;

   // One line of the directed table: either a register write or a sample,
   // where a sample may carry a hand-written expected response.
   typedef struct {
      row_kind_type            kind;
      csr_index_type           csr_sel;
      logic [CSR_DATA_W-1:0]   csr_value;
      req_type                 item;
      bit                      typed;
      rsp_type                 want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow copy of the configuration registers.
   logic [BCOUNT_W-1:0]    cfg_count;
   logic [NUM_BUTTONS-1:0] cfg_mask;
   logic [COUNT_W-1:0]     cfg_down;
   logic [COUNT_W-1:0]     cfg_hold;
   logic [COUNT_W-1:0]     cfg_cycle;

   // Predicted per-button state.
   logic [COUNT_W-1:0] btn_count  [NUM_BUTTONS];
   logic [COUNT_W-1:0] btn_phase  [NUM_BUTTONS];
   logic               btn_active [NUM_BUTTONS];
   btn_event_type      btn_last   [NUM_BUTTONS];

   // Remaining pressed ticks of the press that the generator is playing out.
   int unsigned press_left [NUM_BUTTONS];

   rsp_type     expected_events [$];
   dir_row_type directed_rows [$];
   int unsigned mismatch_count;
   bit          idle_off;

   button_press_event_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Runaway guard.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s", what);
      end
   endtask

   // Gap length: mostly short, now and then a long one.
   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Advance one button by one sample and return the response it gives.
   function automatic rsp_type step_button(input req_type r);
      rsp_type           res;
      logic [2:0]        b;
      int unsigned       n;
      logic [COUNT_W-1:0] cnt;
      logic [COUNT_W-1:0] old_cnt;
      logic [COUNT_W:0]  ph;
      logic              stepped;
      logic              fire;

      b = r.button_index;
      fire = 1'b0;
      res.echo_index = b;
      res.notify = 1'b0;
      res.button_event = EV_NONE;
      n = (cfg_count > NUM_BUTTONS) ? NUM_BUTTONS : cfg_count;
      if (b >= n) begin
         return res;
      end

      if (r.pin_level == cfg_mask[b]) begin
         // Pressed tick: saturating count, then the phase of the hold cycle.
         cnt = btn_count[b];
         stepped = 1'b0;
         if (cnt != COUNT_MAX) begin
            cnt = cnt + 1'b1;
            stepped = 1'b1;
         end
         btn_count[b] = cnt;
         if (cfg_cycle != '0) begin
            ph = {1'b0, btn_phase[b]} + 1'b1;
            if (ph >= {1'b0, cfg_cycle}) begin
               ph = '0;
            end
            btn_phase[b] = ph[COUNT_W-1:0];
         end else begin
            btn_phase[b] = '0;
         end

         // Click-down wins over hold, and hold over a hold-cycle tick.
         if (stepped && cnt == cfg_down) begin
            btn_active[b] = 1'b1;
            btn_last[b] = EV_CLICK_DOWN;
            fire = 1'b1;
         end else if (stepped && cnt == cfg_hold) begin
            btn_active[b] = 1'b1;
            btn_last[b] = EV_HOLD;
            fire = 1'b1;
         end else if (cnt > cfg_hold) begin
            btn_last[b] = EV_HOLD_CYCLE;
            if (cfg_cycle != '0 && btn_phase[b] == '0) begin
               fire = 1'b1;
            end
         end
      end else begin
         // Released tick: clear the counters and close an active press.
         old_cnt = btn_count[b];
         btn_count[b] = '0;
         btn_phase[b] = '0;
         if (btn_active[b]) begin
            if (old_cnt >= cfg_down && old_cnt < cfg_hold) begin
               btn_last[b] = EV_CLICK_UP;
               fire = 1'b1;
            end else if (old_cnt >= cfg_hold) begin
               btn_last[b] = EV_HOLD_UP;
               fire = 1'b1;
            end
            btn_active[b] = 1'b0;
         end
      end

      res.button_event = btn_last[b];
      res.notify = fire;
      return res;
   endfunction

   // Random sample: mostly whole presses of random length, some noise.
   function automatic req_type random_sample();
      req_type     s;
      logic        pressed;
      int unsigned span;

      if (cfg_count != '0 && $urandom_range(0, 9) != 0) begin
         s.button_index = 3'($urandom_range(0, int'(cfg_count) - 1));
      end else begin
         s.button_index = 3'($urandom_range(0, NUM_BUTTONS - 1));
      end
      pressed = cfg_mask[s.button_index];
      if ($urandom_range(0, 9) == 0) begin
         s.pin_level = 1'($urandom_range(0, 1));
      end else if (press_left[s.button_index] != 0) begin
         s.pin_level = pressed;
         press_left[s.button_index]--;
      end else begin
         s.pin_level = ~pressed;
         span = ((cfg_hold < 20) ? int'(cfg_hold) : 20)
              + ((cfg_cycle < 6) ? 3 * int'(cfg_cycle) : 6) + 3;
         press_left[s.button_index] = $urandom_range(0, span);
      end
      return s;
   endfunction

   function automatic void add_sample(input logic [2:0] idx, input logic pin);
      dir_row_type row;
      row.kind = ROW_SAMPLE;
      row.csr_sel = CSR_BUTTON_COUNT;
      row.csr_value = '0;
      row.item.button_index = idx;
      row.item.pin_level = pin;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic [2:0] idx, input logic pin,
                                       input btn_event_type ev, input logic nt);
      add_sample(idx, pin);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want.button_event = ev;
      directed_rows[$].want.notify = nt;
      directed_rows[$].want.echo_index = idx;
   endfunction

   function automatic void add_csr(input csr_index_type sel,
                                   input logic [CSR_DATA_W-1:0] value);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.csr_sel = sel;
      row.csr_value = value;
      row.item = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   // Register write, mirrored into the shadow configuration on acceptance.
   task automatic write_csr(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (sel)
         CSR_BUTTON_COUNT:     cfg_count = value[BCOUNT_W-1:0];
         CSR_PRESS_LEVEL_MASK: cfg_mask  = value[NUM_BUTTONS-1:0];
         CSR_DOWN_TICKS:       cfg_down  = value;
         CSR_HOLD_TICKS:       cfg_hold  = value;
         CSR_HOLD_CYCLE_TICKS: cfg_cycle = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one request after an optional gap and predict its response.
   task automatic send_sample(input req_type item, input bit typed, input rsp_type want);
      int unsigned gap;
      rsp_type     exp;

      gap = 0;
      if (!idle_off && $urandom_range(0, 9) >= 6) begin
         gap = draw_gap();
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      exp = step_button(item);
      if (typed) begin
         exp = want;
      end
      expected_events.push_back(exp);
   endtask

   // Stop offering requests and wait until every response is back.
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Configuration of each random phase, extremes included.
   task automatic configure_phase(input int phase);
      int unsigned d;
      int unsigned h;
      case (phase)
         0: begin
            d = $urandom_range(1, 3);
            h = d + $urandom_range(1, 8);
            write_csr(CSR_BUTTON_COUNT, 16'(NUM_BUTTONS));
            write_csr(CSR_PRESS_LEVEL_MASK, 16'($urandom_range(0, 255)));
            write_csr(CSR_DOWN_TICKS, 16'(d));
            write_csr(CSR_HOLD_TICKS, 16'(h));
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'd0);
         end
         1: begin
            write_csr(CSR_BUTTON_COUNT, 16'(NUM_BUTTONS));
            write_csr(CSR_PRESS_LEVEL_MASK, 16'h00FF);
            write_csr(CSR_DOWN_TICKS, 16'd1);
            write_csr(CSR_HOLD_TICKS, 16'd1);
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'd1);
         end
         2: begin
            write_csr(CSR_BUTTON_COUNT, 16'd5);
            write_csr(CSR_PRESS_LEVEL_MASK, 16'h0000);
            write_csr(CSR_DOWN_TICKS, 16'($urandom_range(2, 4)));
            write_csr(CSR_HOLD_TICKS, 16'($urandom_range(6, 12)));
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'($urandom_range(2, 4)));
         end
         3: begin
            write_csr(CSR_BUTTON_COUNT, 16'd1);
            write_csr(CSR_PRESS_LEVEL_MASK, 16'($urandom_range(0, 255)));
            write_csr(CSR_DOWN_TICKS, 16'($urandom_range(1, 3)));
            write_csr(CSR_HOLD_TICKS, 16'hFFFF);
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'd3);
         end
         4: begin
            write_csr(CSR_BUTTON_COUNT, 16'($urandom_range(1, NUM_BUTTONS)));
            write_csr(CSR_PRESS_LEVEL_MASK, 16'($urandom_range(0, 255)));
            write_csr(CSR_DOWN_TICKS, 16'($urandom_range(1, 6)));
            write_csr(CSR_HOLD_TICKS, 16'($urandom_range(1, 14)));
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'hFFFF);
         end
         default: begin
            write_csr(CSR_BUTTON_COUNT, 16'(NUM_BUTTONS));
            write_csr(CSR_PRESS_LEVEL_MASK, 16'($urandom_range(0, 255)));
            write_csr(CSR_DOWN_TICKS, 16'($urandom_range(0, 5)));
            write_csr(CSR_HOLD_TICKS, 16'($urandom_range(0, 10)));
            write_csr(CSR_HOLD_CYCLE_TICKS, 16'($urandom_range(0, 5)));
         end
      endcase
   endtask

   // Response side: random stalls unless idling is switched off.
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_off || stall_left == 0) begin
            rsp_ready <= 1'b1;
            if (!idle_off && $urandom_range(0, 3) == 0) begin
               stall_left = draw_gap();
            end
         end else begin
            rsp_ready <= 1'b0;
            stall_left--;
         end
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            log_mismatch($sformatf("Unexpected response: event %0d notify %0d index %0d",
                                   rsp_data.button_event, rsp_data.notify,
                                   rsp_data.echo_index));
         end else begin
            exp = expected_events.pop_front();
            if (rsp_data.button_event !== exp.button_event ||
                rsp_data.notify !== exp.notify ||
                rsp_data.echo_index !== exp.echo_index) begin
               log_mismatch($sformatf(
                  "Mismatch: expected event %0d notify %0d index %0d, got %0d %0d %0d",
                  exp.button_event, exp.notify, exp.echo_index,
                  rsp_data.button_event, rsp_data.notify, rsp_data.echo_index));
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type row;
      req_type     sample;
      int unsigned registered;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BUTTON_COUNT;
      csr_data  <= '0;
      idle_off = 1'b0;
      mismatch_count = 0;
      cfg_count = '0;
      cfg_mask  = '0;
      cfg_down  = 16'd3;
      cfg_hold  = 16'd100;
      cfg_cycle = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         btn_count[i]  = '0;
         btn_phase[i]  = '0;
         btn_active[i] = 1'b0;
         btn_last[i]   = EV_NONE;
         press_left[i] = 0;
      end

      // After reset no button is registered.
      add_checked(3'd0, 1'b1, EV_NONE, 1'b0);
      add_checked(3'd7, 1'b0, EV_NONE, 1'b0);
      // Button 0 pressed high, the rest pressed low; short thresholds.
      add_csr(CSR_BUTTON_COUNT, 16'(NUM_BUTTONS));
      add_csr(CSR_PRESS_LEVEL_MASK, 16'h0001);
      add_csr(CSR_DOWN_TICKS, 16'd2);
      add_csr(CSR_HOLD_TICKS, 16'd4);
      add_csr(CSR_HOLD_CYCLE_TICKS, 16'd2);
      add_checked(3'd0, 1'b1, EV_NONE, 1'b0);
      add_checked(3'd0, 1'b1, EV_CLICK_DOWN, 1'b1);
      add_checked(3'd0, 1'b0, EV_CLICK_UP, 1'b1);
      add_checked(3'd0, 1'b0, EV_CLICK_UP, 1'b0);
      // Long press through hold and hold-cycle ticks, then hold-up.
      repeat (6) add_sample(3'd1, 1'b0);
      add_sample(3'd1, 1'b1);
      // Equal thresholds: click-down takes the tick.
      add_csr(CSR_DOWN_TICKS, 16'd3);
      add_csr(CSR_HOLD_TICKS, 16'd3);
      repeat (3) add_sample(3'd2, 1'b0);
      add_sample(3'd2, 1'b1);
      // Zero thresholds and no hold-cycle period.
      add_csr(CSR_DOWN_TICKS, 16'd0);
      add_csr(CSR_HOLD_TICKS, 16'd0);
      add_csr(CSR_HOLD_CYCLE_TICKS, 16'd0);
      repeat (2) add_sample(3'd3, 1'b0);
      add_sample(3'd3, 1'b1);
      // Fewer registered buttons: higher indexes are ignored.
      add_csr(CSR_BUTTON_COUNT, 16'd4);
      add_checked(3'd5, 1'b1, EV_NONE, 1'b0);
      add_checked(3'd7, 1'b1, EV_NONE, 1'b0);
      add_sample(3'd3, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain_requests();
            write_csr(row.csr_sel, row.csr_value);
         end else begin
            send_sample(row.item, row.typed, row.want);
         end
      end

      // Random phases, each under its own configuration.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_requests();
         configure_phase(phase);
         idle_off = (phase == 1);
         registered = 0;
         while (registered < PHASE_SAMPLES) begin
            sample = random_sample();
            if (sample.button_index < cfg_count) begin
               registered++;
            end
            send_sample(sample, 1'b0, '0);
         end
         idle_off = 1'b0;
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_events.size() != 0) begin
         log_mismatch($sformatf("%0d responses never arrived", expected_events.size()));
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
